/* sv/ps2m_pkg.sv */
package ps2m_pkg;

  localparam int unsigned CFG_W       = 13;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned OUT_COORD_W = 12;
  localparam int unsigned OUT_DELTA_W = 16;
  localparam int unsigned BTN_W       = 3;
  localparam int unsigned FLAG_W      = 5;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [31:0]      POS_X_RESET  = 32'd320;
  localparam logic [31:0]      POS_Y_RESET  = 32'd240;

  localparam int unsigned SYNC_BIT  = 3;
  localparam int unsigned X_OVF_BIT = 6;
  localparam int unsigned Y_OVF_BIT = 7;

  localparam int unsigned BTN_LEFT  = 0;
  localparam int unsigned BTN_RIGHT = 1;

  localparam int unsigned FLAG_LBTN_DOWN = 0;
  localparam int unsigned FLAG_LBTN_UP   = 1;
  localparam int unsigned FLAG_RBTN_DOWN = 2;
  localparam int unsigned FLAG_RBTN_UP   = 3;
  localparam int unsigned FLAG_MOVED     = 4;

  typedef struct packed {
    logic       is_read;
    logic [7:0] hdr;
    logic [7:0] xb;
    logic [7:0] yb;
  } cmd_t;

  typedef struct packed {
    logic [OUT_COORD_W-1:0] cursor_x;
    logic [OUT_COORD_W-1:0] cursor_y;
    logic [OUT_DELTA_W-1:0] delta_x;
    logic [OUT_DELTA_W-1:0] delta_y;
    logic [BTN_W-1:0]       buttons;
    logic [FLAG_W-1:0]      flags;
  } res_t;

endpackage

/* sv/ps2m_in_if.sv */
interface ps2m_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] data_byte;

  modport source (output valid, output opcode, output data_byte, input ready);
  modport sink (input valid, input opcode, input data_byte, output ready);
endinterface

/* sv/ps2m_out_if.sv */
interface ps2m_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] cursor_x;
  logic [11:0] cursor_y;
  logic [15:0] delta_x;
  logic [15:0] delta_y;
  logic [2:0]  buttons;
  logic        lbtn_down;
  logic        lbtn_up;
  logic        rbtn_down;
  logic        rbtn_up;
  logic        moved;

  modport source (
    output valid, output cursor_x, output cursor_y, output delta_x, output delta_y,
    output buttons, output lbtn_down, output lbtn_up, output rbtn_down,
    output rbtn_up, output moved, input ready
  );
  modport sink (
    input valid, input cursor_x, input cursor_y, input delta_x, input delta_y,
    input buttons, input lbtn_down, input lbtn_up, input rbtn_down,
    input rbtn_up, input moved, output ready
  );
endinterface

/* sv/ps2m_cfg_if.sv */
interface ps2m_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [12:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* sv/ps2m_front.sv */
module ps2m_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  ps2m_in_if.sink       in_i,
  input  logic          q_full_i,
  output logic          push_o,
  output ps2m_pkg::cmd_t push_cmd_o
);
  import ps2m_pkg::*;

  localparam logic [1:0] IDX_HEADER = 2'd0;
  localparam logic [1:0] IDX_X      = 2'd1;
  localparam logic [1:0] IDX_Y      = 2'd2;

  logic [1:0] idx_q, idx_d;
  logic [7:0] hdr_q, hdr_d;
  logic [7:0] xb_q, xb_d;
  logic       accept;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    idx_d              = idx_q;
    hdr_d              = hdr_q;
    xb_d               = xb_q;
    push_o             = 1'b0;
    push_cmd_o.is_read = 1'b0;
    push_cmd_o.hdr     = hdr_q;
    push_cmd_o.xb      = xb_q;
    push_cmd_o.yb      = in_i.data_byte;
    if (accept) begin
      if (in_i.opcode == OP_READ) begin
        push_o             = 1'b1;
        push_cmd_o.is_read = 1'b1;
      end else begin
        case (idx_q)
          IDX_HEADER: begin
            if (in_i.data_byte[SYNC_BIT]) begin
              hdr_d = in_i.data_byte;
              idx_d = IDX_X;
            end
          end
          IDX_X: begin
            xb_d  = in_i.data_byte;
            idx_d = IDX_Y;
          end
          default: begin
            idx_d  = IDX_HEADER;
            push_o = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= IDX_HEADER;
      hdr_q <= '0;
      xb_q  <= '0;
    end else begin
      idx_q <= idx_d;
      hdr_q <= hdr_d;
      xb_q  <= xb_d;
    end
  end

endmodule

/* sv/ps2m_queue.sv */
module ps2m_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ps2m_pkg::cmd_t push_cmd_i,
  output logic           full_o,
  output logic           cmd_valid_o,
  output ps2m_pkg::cmd_t cmd_o,
  input  logic           pop_i
);
  import ps2m_pkg::*;

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o      = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = mem_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

/* sv/ps2m_back.sv */
module ps2m_back #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned ACCUM_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [ps2m_pkg::CFG_W-1:0] width_i,
  input  logic [ps2m_pkg::CFG_W-1:0] height_i,
  input  logic                       cmd_valid_i,
  input  ps2m_pkg::cmd_t             cmd_i,
  output logic                       pop_o,
  ps2m_out_if.source                 res_o
);
  import ps2m_pkg::*;

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned AW = ACCUM_BITS;
  localparam logic signed [AW:0] ACC_HI = {2'b00, {(AW-1){1'b1}}};
  localparam logic signed [AW:0] ACC_LO = {2'b11, {(AW-1){1'b0}}};

  logic [BTN_W-1:0]     btn_q, btn_d;
  logic [CB-1:0]        pos_x_q, pos_x_d;
  logic [CB-1:0]        pos_y_q, pos_y_d;
  logic signed [AW-1:0] acc_x_q, acc_x_d;
  logic signed [AW-1:0] acc_y_q, acc_y_d;
  logic [FLAG_W-1:0]    flags_q, flags_d;
  logic                 out_valid_q, out_valid_d;
  res_t                 res_q, res_d;

  logic signed [8:0]    dx, dy, dyn;
  logic [BTN_W-1:0]     btn_new;
  logic                 motion;
  logic signed [AW:0]   sum_x, sum_y;
  logic signed [CB+1:0] vx, vy;
  logic signed [31:0]   ax32, ay32;
  logic                 can_load;

  function automatic logic [CB:0] eff_bound(input logic [CFG_W-1:0] cfg);
    logic [31:0] c32;
    c32 = 32'(cfg);
    if (c32 > (32'd1 << CB)) begin
      c32 = 32'd1 << CB;
    end
    return c32[CB:0];
  endfunction

  function automatic logic [CB-1:0] clamp_axis(input logic signed [CB+1:0] v,
                                               input logic [CB:0] b);
    logic [CB:0] bm1;
    bm1 = b - 1'b1;
    if (v < 0) begin
      return '0;
    end else if (v >= signed'({1'b0, b})) begin
      return bm1[CB-1:0];
    end else begin
      return v[CB-1:0];
    end
  endfunction

  function automatic logic signed [AW-1:0] sat(input logic signed [AW:0] s);
    logic signed [AW:0] r;
    r = s;
    if (s > ACC_HI) begin
      r = ACC_HI;
    end else if (s < ACC_LO) begin
      r = ACC_LO;
    end
    return r[AW-1:0];
  endfunction

  assign can_load = !out_valid_q || res_o.ready;
  assign pop_o    = cmd_valid_i && (!cmd_i.is_read || can_load);

  always_comb begin
    dx      = cmd_i.hdr[X_OVF_BIT] ? '0 : signed'({cmd_i.xb[7], cmd_i.xb});
    dy      = cmd_i.hdr[Y_OVF_BIT] ? '0 : signed'({cmd_i.yb[7], cmd_i.yb});
    dyn     = -dy;
    btn_new = cmd_i.hdr[BTN_W-1:0];
    motion  = (dx != '0) || (dy != '0);
    sum_x   = (AW+1)'(acc_x_q) + (AW+1)'(dx);
    sum_y   = (AW+1)'(acc_y_q) + (AW+1)'(dyn);
    vx      = signed'({2'b00, pos_x_q}) + (CB+2)'(dx);
    vy      = signed'({2'b00, pos_y_q}) + (CB+2)'(dyn);
    ax32    = 32'(acc_x_q);
    ay32    = 32'(acc_y_q);
  end

  always_comb begin
    btn_d       = btn_q;
    pos_x_d     = pos_x_q;
    pos_y_d     = pos_y_q;
    acc_x_d     = acc_x_q;
    acc_y_d     = acc_y_q;
    flags_d     = flags_q;
    out_valid_d = out_valid_q;
    res_d       = res_q;
    if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (pop_o) begin
      if (cmd_i.is_read) begin
        out_valid_d    = 1'b1;
        res_d.cursor_x = OUT_COORD_W'(32'(pos_x_q));
        res_d.cursor_y = OUT_COORD_W'(32'(pos_y_q));
        res_d.delta_x  = ax32[OUT_DELTA_W-1:0];
        res_d.delta_y  = ay32[OUT_DELTA_W-1:0];
        res_d.buttons  = btn_q;
        res_d.flags    = flags_q;
        acc_x_d        = '0;
        acc_y_d        = '0;
        flags_d        = '0;
      end else begin
        btn_d = btn_new;
        if (btn_new[BTN_LEFT] && !btn_q[BTN_LEFT]) begin
          flags_d[FLAG_LBTN_DOWN] = 1'b1;
        end
        if (!btn_new[BTN_LEFT] && btn_q[BTN_LEFT]) begin
          flags_d[FLAG_LBTN_UP] = 1'b1;
        end
        if (btn_new[BTN_RIGHT] && !btn_q[BTN_RIGHT]) begin
          flags_d[FLAG_RBTN_DOWN] = 1'b1;
        end
        if (!btn_new[BTN_RIGHT] && btn_q[BTN_RIGHT]) begin
          flags_d[FLAG_RBTN_UP] = 1'b1;
        end
        if (motion) begin
          acc_x_d             = sat(sum_x);
          acc_y_d             = sat(sum_y);
          pos_x_d             = clamp_axis(vx, eff_bound(width_i));
          pos_y_d             = clamp_axis(vy, eff_bound(height_i));
          flags_d[FLAG_MOVED] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      btn_q       <= '0;
      pos_x_q     <= POS_X_RESET[CB-1:0];
      pos_y_q     <= POS_Y_RESET[CB-1:0];
      acc_x_q     <= '0;
      acc_y_q     <= '0;
      flags_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      btn_q       <= btn_d;
      pos_x_q     <= pos_x_d;
      pos_y_q     <= pos_y_d;
      acc_x_q     <= acc_x_d;
      acc_y_q     <= acc_y_d;
      flags_q     <= flags_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.cursor_x  = res_q.cursor_x;
  assign res_o.cursor_y  = res_q.cursor_y;
  assign res_o.delta_x   = res_q.delta_x;
  assign res_o.delta_y   = res_q.delta_y;
  assign res_o.buttons   = res_q.buttons;
  assign res_o.lbtn_down = res_q.flags[FLAG_LBTN_DOWN];
  assign res_o.lbtn_up   = res_q.flags[FLAG_LBTN_UP];
  assign res_o.rbtn_down = res_q.flags[FLAG_RBTN_DOWN];
  assign res_o.rbtn_up   = res_q.flags[FLAG_RBTN_UP];
  assign res_o.moved     = res_q.flags[FLAG_MOVED];

endmodule

/* sv/ps2_mouse_packet_decoder.sv */
// ps2 mouse packet decoder, 3-byte standard packets
// in_i: one transaction per received mouse byte (opcode byte) or per read
// request (opcode read); data_byte is ignored for reads.
// res_o: one transaction per read, carrying cursor position, accumulated
// deltas, buttons and sticky event flags as they stood before the read
// cleared the deltas and flags. bytes produce no transaction.
// cfg_i: index 0 screen width, index 1 screen height; a zero write is
// dropped. write only while the block is idle; always ready.
// throughput: one input transaction per cycle while the queue has room.
// the front assembles packets, a two-entry command queue feeds the back,
// which retires one command per cycle unless a read meets a held result,
// and owns the result register. a read goes from the queue into the
// result register on res_o, behind any commands still queued ahead of it.
// reset: cursor at 320,240 (masked to the coordinate width), bounds
// 640x480, deltas, buttons and flags zero, packet framing at header.
// stall: the result holds on res_o until taken; packets keep retiring
// behind it, a following read waits in the queue, and in_i drops ready
// once the queue is full.
module ps2_mouse_packet_decoder #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned ACCUM_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ps2m_in_if.sink    in_i,
  ps2m_out_if.source res_o,
  ps2m_cfg_if.sink   cfg_i
);
  import ps2m_pkg::*;

  logic [CFG_W-1:0] width_q, width_d;
  logic [CFG_W-1:0] height_q, height_d;
  logic             push, q_full, cmd_valid, pop;
  cmd_t             push_cmd, cmd;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_i.valid && cfg_i.ready && (cfg_i.data != '0)) begin
      case (cfg_i.index)
        REG_SCREEN_WIDTH:  width_d  = cfg_i.data;
        REG_SCREEN_HEIGHT: height_d = cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  ps2m_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  ps2m_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_cmd_i  (push_cmd),
    .full_o      (q_full),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .pop_i       (pop)
  );

  ps2m_back #(
    .COORD_BITS (COORD_BITS),
    .ACCUM_BITS (ACCUM_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .width_i     (width_q),
    .height_i    (height_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .pop_o       (pop),
    .res_o       (res_o)
  );

endmodule

/* bench/ps2m_report_checker.sv */
module ps2m_report_checker (
  input  logic clk_i,
  input  logic rst_ni,
  ps2m_in_if   in_mon,
  ps2m_out_if  res_mon,
  ps2m_cfg_if  cfg_mon,
  output int   fail_count_o,
  output int   pending_o
);
  import ps2m_pkg::*;

  localparam int COORD_LIM = 1 << OUT_COORD_W;
  localparam int DELTA_MAX = (1 << (OUT_DELTA_W - 1)) - 1;
  localparam int DELTA_MIN = -DELTA_MAX - 1;

  logic [1:0]       frame_pos;
  logic [7:0]       hdr_q;
  logic [7:0]       xmot_q;
  logic [BTN_W-1:0] btn_q;
  logic [11:0]      cur_x;
  logic [11:0]      cur_y;
  int               acc_x;
  int               acc_y;
  logic [4:0]       ev_flags;
  logic [12:0]      bound_w;
  logic [12:0]      bound_h;

  res_t expected_reports[$];
  res_t seen;
  res_t want;
  int   mismatches = 0;
  int   n_pending = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = n_pending;

  function automatic logic [11:0] clamp_coord(input int v, input logic [12:0] bound);
    int lim;
    int c;
    lim = (int'(bound) > COORD_LIM) ? COORD_LIM : int'(bound);
    if (lim < 1) lim = 1;
    c = v;
    if (c < 0) c = 0;
    if (c >= lim) c = lim - 1;
    return c[11:0];
  endfunction

  function automatic int sat_delta(input int a, input int d);
    int s;
    s = a + d;
    if (s > DELTA_MAX) s = DELTA_MAX;
    if (s < DELTA_MIN) s = DELTA_MIN;
    return s;
  endfunction

  // third byte closes the packet: buttons, edge flags, motion
  function automatic void retire_packet(input logic [7:0] yb);
    int dx;
    int dy;
    logic [BTN_W-1:0] now_b;
    dx = hdr_q[X_OVF_BIT] ? 0 : int'($signed(xmot_q));
    dy = hdr_q[Y_OVF_BIT] ? 0 : int'($signed(yb));
    now_b = hdr_q[2:0];
    if (now_b[BTN_LEFT] && !btn_q[BTN_LEFT]) ev_flags[FLAG_LBTN_DOWN] = 1'b1;
    if (!now_b[BTN_LEFT] && btn_q[BTN_LEFT]) ev_flags[FLAG_LBTN_UP] = 1'b1;
    if (now_b[BTN_RIGHT] && !btn_q[BTN_RIGHT]) ev_flags[FLAG_RBTN_DOWN] = 1'b1;
    if (!now_b[BTN_RIGHT] && btn_q[BTN_RIGHT]) ev_flags[FLAG_RBTN_UP] = 1'b1;
    btn_q = now_b;
    if (dx != 0 || dy != 0) begin
      acc_x = sat_delta(acc_x, dx);
      acc_y = sat_delta(acc_y, -dy);
      cur_x = clamp_coord(int'(cur_x) + dx, bound_w);
      cur_y = clamp_coord(int'(cur_y) - dy, bound_h);
      ev_flags[FLAG_MOVED] = 1'b1;
    end
  endfunction

  task automatic report(input string why, input res_t want_r, input res_t got_r);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: expected x=%0d y=%0d dx=%0d dy=%0d btn=%b flags=%b",
               why, want_r.cursor_x, want_r.cursor_y, $signed(want_r.delta_x),
               $signed(want_r.delta_y), want_r.buttons, want_r.flags);
      $display("  got x=%0d y=%0d dx=%0d dy=%0d btn=%b flags=%b",
               got_r.cursor_x, got_r.cursor_y, $signed(got_r.delta_x),
               $signed(got_r.delta_y), got_r.buttons, got_r.flags);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_pos = 2'd0;
      hdr_q     = 8'h00;
      xmot_q    = 8'h00;
      btn_q     = '0;
      cur_x     = POS_X_RESET[11:0];
      cur_y     = POS_Y_RESET[11:0];
      acc_x     = 0;
      acc_y     = 0;
      ev_flags  = '0;
      bound_w   = WIDTH_RESET;
      bound_h   = HEIGHT_RESET;
      expected_reports.delete();
      n_pending = 0;
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        seen.cursor_x = res_mon.cursor_x;
        seen.cursor_y = res_mon.cursor_y;
        seen.delta_x  = res_mon.delta_x;
        seen.delta_y  = res_mon.delta_y;
        seen.buttons  = res_mon.buttons;
        seen.flags[FLAG_LBTN_DOWN] = res_mon.lbtn_down;
        seen.flags[FLAG_LBTN_UP]   = res_mon.lbtn_up;
        seen.flags[FLAG_RBTN_DOWN] = res_mon.rbtn_down;
        seen.flags[FLAG_RBTN_UP]   = res_mon.rbtn_up;
        seen.flags[FLAG_MOVED]     = res_mon.moved;
        if (expected_reports.size() == 0) begin
          report("result with no read outstanding", '0, seen);
        end else begin
          want = expected_reports.pop_front();
          if (seen !== want) report("result mismatch", want, seen);
        end
      end
      if (cfg_mon.valid && cfg_mon.ready && cfg_mon.data != '0) begin
        if (cfg_mon.index == REG_SCREEN_WIDTH) bound_w = cfg_mon.data;
        else bound_h = cfg_mon.data;
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.opcode == OP_BYTE) begin
          case (frame_pos)
            2'd0: begin
              if (in_mon.data_byte[SYNC_BIT]) begin
                hdr_q     = in_mon.data_byte;
                frame_pos = 2'd1;
              end
            end
            2'd1: begin
              xmot_q    = in_mon.data_byte;
              frame_pos = 2'd2;
            end
            default: begin
              frame_pos = 2'd0;
              retire_packet(in_mon.data_byte);
            end
          endcase
        end else begin
          want.cursor_x = cur_x;
          want.cursor_y = cur_y;
          want.delta_x  = acc_x[15:0];
          want.delta_y  = acc_y[15:0];
          want.buttons  = btn_q;
          want.flags    = ev_flags;
          expected_reports.push_back(want);
          acc_x    = 0;
          acc_y    = 0;
          ev_flags = '0;
        end
      end
      n_pending = expected_reports.size();
    end
  end

endmodule

/* bench/testbench.sv */
module testbench;
  import ps2m_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 300;

  logic clk_i = 1'b0;
  logic rst_ni;

  ps2m_in_if  in_if ();
  ps2m_out_if res_if ();
  ps2m_cfg_if cfg_if ();

  int   fail_count;
  int   pending;
  int   cycles = 0;
  int   burst_left = 0;
  int   items_sent = 0;
  int   reads_sent = 0;
  int   cfg_writes = 0;
  logic hold_req = 1'b0;

  ps2_mouse_packet_decoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  ps2m_report_checker report_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_if),
    .res_mon      (res_if),
    .cfg_mon      (cfg_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: changing stall pattern plus one long hold-off on request
  initial begin : receiver
    int   hold_cnt;
    int   mode;
    int   span;
    logic hold_used;
    hold_cnt  = 0;
    mode      = 0;
    span      = 0;
    hold_used = 1'b0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_used) begin
        hold_used = 1'b1;
        hold_cnt  = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        res_if.ready = 1'b0;
        hold_cnt--;
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(8, 80);
        end
        span--;
        case (mode)
          0: res_if.ready = 1'b1;
          1: res_if.ready = 1'($urandom_range(0, 1));
          2: res_if.ready = ($urandom_range(0, 3) == 0);
          default: res_if.ready = ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  task automatic push_item(input logic op, input logic [7:0] b);
    @(negedge clk_i);
    if (burst_left == 0) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    in_if.valid     = 1'b1;
    in_if.opcode    = op;
    in_if.data_byte = b;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    items_sent++;
    if (op == OP_READ) reads_sent++;
  endtask

  task automatic send_packet(input logic [7:0] h, input logic [7:0] x, input logic [7:0] y);
    push_item(OP_BYTE, h);
    push_item(OP_BYTE, x);
    push_item(OP_BYTE, y);
  endtask

  task automatic send_read();
    push_item(OP_READ, 8'($urandom_range(0, 255)));
  endtask

  task automatic sender_idle();
    @(negedge clk_i);
    in_if.valid = 1'b0;
  endtask

  task automatic write_reg(input logic idx, input logic [12:0] v);
    @(negedge clk_i);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = v;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_writes++;
  endtask

  // drain, let queued bytes retire, then reprogram the bounds
  task automatic set_bounds(input logic [12:0] w, input logic [12:0] h, input bit zero_too);
    sender_idle();
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    write_reg(REG_SCREEN_WIDTH, w);
    write_reg(REG_SCREEN_HEIGHT, h);
    if (zero_too) begin
      write_reg(REG_SCREEN_WIDTH, 13'd0);
      write_reg(REG_SCREEN_HEIGHT, 13'd0);
    end
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  function automatic logic [7:0] pick_motion();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'h7F;
      2: return 8'h80;
      3: return ($urandom_range(0, 1) != 0) ? 8'h01 : 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_header();
    logic [7:0] h;
    h = 8'($urandom_range(0, 255));
    h[SYNC_BIT] = 1'b1;
    if ($urandom_range(0, 7) != 0) h[X_OVF_BIT] = 1'b0;
    if ($urandom_range(0, 7) != 0) h[Y_OVF_BIT] = 1'b0;
    return h;
  endfunction

  task automatic run_random(input int n);
    int start;
    start = items_sent;
    while (items_sent - start < n) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: send_packet(pick_header(), pick_motion(), pick_motion());
        6, 7: send_read();
        8: push_item(OP_BYTE, 8'($urandom_range(0, 255)));
        default: begin
          // read in the middle of a packet, framing left open
          push_item(OP_BYTE, pick_header());
          send_read();
          push_item(OP_BYTE, pick_motion());
        end
      endcase
    end
  endtask

  // one-direction run of large motion, pushing the cursor into the bounds
  task automatic sweep_motion(input bit up);
    logic [7:0] mx;
    logic [7:0] my;
    repeat (20) begin
      mx = up ? 8'($urandom_range(100, 127)) : 8'(256 - $urandom_range(100, 128));
      my = up ? 8'(256 - $urandom_range(100, 128)) : 8'($urandom_range(100, 127));
      send_packet({5'b00001, 3'($urandom_range(0, 7))}, mx, my);
    end
    repeat (3) send_packet(8'h08, up ? 8'hF0 : 8'h10, up ? 8'h10 : 8'hF0);
    send_read();
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.opcode    = OP_BYTE;
    in_if.data_byte = 8'h00;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = REG_SCREEN_WIDTH;
    cfg_if.data     = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    push_item(OP_READ, 8'h00);
    send_packet(8'h08, 8'h7F, 8'h80);
    push_item(OP_READ, 8'hFF);
    push_item(OP_BYTE, 8'hF7);
    send_packet(8'hC9, 8'hFF, 8'h01);
    send_packet(8'h0A, 8'h80, 8'h7F);
    send_read();
    send_packet(8'h4C, 8'h05, 8'h00);
    send_packet(8'h88, 8'h01, 8'hFF);
    send_read();
    push_item(OP_BYTE, 8'h00);
    send_packet(8'h3F, 8'h00, 8'h00);
    send_read();
    run_random(50);

    set_bounds(13'd1, 13'd1, 1'b0);
    run_random(40);

    set_bounds(13'd8191, 13'd4096, 1'b1);
    sweep_motion(1'b1);
    sweep_motion(1'b0);
    run_random(40);

    set_bounds(13'($urandom_range(2, 64)), 13'($urandom_range(2, 64)), 1'b0);
    burst_left = 40;
    hold_req   = 1'b1;
    repeat (12) send_read();
    run_random(40);

    set_bounds(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)), 1'b0);
    run_random(50);

    set_bounds(13'd4096, 13'd1, 1'b0);
    run_random(30);

    sender_idle();
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);

    $display("sent %0d input transactions (%0d reads) and %0d register writes",
             items_sent, reads_sent, cfg_writes);
    $display("covered sync loss, overflow, button edges, bound extremes and stalls");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
